### rtl/upd_pkg.sv
package upd_pkg;

    localparam int unsigned ByteW = 8;

    localparam logic [ByteW-1:0] ChPercent = 8'h25;
    localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
    localparam logic [ByteW-1:0] ChSpace   = 8'h20;
    localparam logic [ByteW-1:0] ChNine    = 8'h39;
    localparam logic [ByteW-1:0] ChZed     = 8'h5A;
    localparam logic [ByteW-1:0] ChZero    = 8'h30;
    localparam logic [ByteW-1:0] ChUpperA  = 8'h41;
    localparam logic [ByteW-1:0] ChLowerA  = 8'h61;
    localparam logic [ByteW-1:0] NibbleTen = 8'd10;

    // escape progress
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_FIRST   = 2'd2
    } phase_t;

    // result count of one item
    typedef logic [1:0] res_cnt_t;

    function automatic logic [ByteW-1:0] plain_map(input logic [ByteW-1:0] b);
        plain_map = (b == ChPlus) ? ChSpace : b;
    endfunction

    // signed compare: top-bit-set bytes count as below '9'
    function automatic logic [ByteW-1:0] nibble_of(input logic [ByteW-1:0] b);
        if (b[ByteW-1] || (b <= ChNine)) begin
            nibble_of = b - ChZero;
        end
        else if (b <= ChZed) begin
            nibble_of = b - ChUpperA + NibbleTen;
        end
        else begin
            nibble_of = b - ChLowerA + NibbleTen;
        end
    endfunction

endpackage

### rtl/url_percent_decoder_unit.sv
// URL percent decoder (form-urlencoded). One encoded byte per input item, tlast
// on the final byte of a string; decoded bytes leave on the master side with
// tlast on the final decoded byte. '+' becomes a space, "%hh" becomes one byte
// with no hex check, and a '%' cut short by the end of the string is passed
// literally. Items pass through the input register and then the two-entry
// result buffer. Throughput is one item per cycle while the master side is
// ready; the only other stall comes when a '%' and a single final byte yield
// two results at once and the buffer still holds one after the pop. Master
// backpressure reaches s_axis_tready combinationally via the buffer fill check.
module url_percent_decoder_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [upd_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] in_byte
    input  logic                     s_axis_tlast,  // end_of_string
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    output logic [upd_pkg::ByteW-1:0] m_axis_tdata,  // [7:0] out_byte
    output logic                     m_axis_tlast,  // out_last
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready
);
    import upd_pkg::*;

    // input register
    logic             in_valid_reg, in_valid_next;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;

    // escape state
    phase_t           phase_reg, phase_next;
    logic [ByteW-1:0] first_hex_reg, first_hex_next;

    // two-entry result buffer, entry 0 is the head
    logic [ByteW-1:0] buf_data_reg [2];
    logic [ByteW-1:0] buf_data_next [2];
    logic             buf_last_reg [2];
    logic             buf_last_next [2];
    logic [1:0]       buf_cnt_reg, buf_cnt_next;

    // results of the item in the input register
    res_cnt_t         res_n;
    logic [ByteW-1:0] res0_data, res1_data;
    logic             res0_last, res1_last;

    // nibble values of the escape bytes
    logic [ByteW-1:0] hi_nib;
    logic [ByteW-1:0] lo_nib;

    logic             pop;
    logic [1:0]       rem_cnt;
    logic             consume;
    logic             accept;

    assign pop     = (buf_cnt_reg != 2'd0) && m_axis_tready;
    assign rem_cnt = buf_cnt_reg - {1'b0, pop};
    // the item leaves the input register once its results fit in the buffer
    assign consume = in_valid_reg && (({1'b0, rem_cnt} + {1'b0, res_n}) <= 3'd2);
    assign s_axis_tready = !in_valid_reg || consume;
    assign accept  = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (buf_cnt_reg != 2'd0);
    assign m_axis_tdata  = buf_data_reg[0];
    assign m_axis_tlast  = buf_last_reg[0];

    assign hi_nib = nibble_of(first_hex_reg);
    assign lo_nib = nibble_of(in_byte_reg);

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        first_hex_next = first_hex_reg;
        if (consume) begin
            unique case (phase_reg)
                PH_PERCENT: begin
                    if (in_last_reg) begin
                        phase_next = PH_IDLE;
                    end
                    else begin
                        phase_next     = PH_FIRST;
                        first_hex_next = in_byte_reg;
                    end
                end
                PH_FIRST: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    if ((in_byte_reg == ChPercent) && !in_last_reg) begin
                        phase_next = PH_PERCENT;
                    end
                    else begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    // results
    always_comb
    begin
        res_n     = 2'd1;
        res0_data = plain_map(in_byte_reg);
        res0_last = in_last_reg;
        res1_data = plain_map(in_byte_reg);
        res1_last = 1'b1;
        unique case (phase_reg)
            PH_PERCENT: begin
                // '%' then the final byte: both go out literally
                res_n     = in_last_reg ? 2'd2 : 2'd0;
                res0_data = ChPercent;
                res0_last = 1'b0;
            end
            PH_FIRST: begin
                res0_data = {hi_nib[3:0], 4'h0} | lo_nib;
            end
            default: begin
                if (in_byte_reg == ChPercent) begin
                    res_n     = in_last_reg ? 2'd1 : 2'd0;
                    res0_data = ChPercent;
                end
            end
        endcase
        if (!in_valid_reg) begin
            res_n = 2'd0;
        end
    end

    // buffer update
    always_comb
    begin
        buf_data_next[0] = pop ? buf_data_reg[1] : buf_data_reg[0];
        buf_last_next[0] = pop ? buf_last_reg[1] : buf_last_reg[0];
        buf_data_next[1] = buf_data_reg[1];
        buf_last_next[1] = buf_last_reg[1];
        buf_cnt_next     = rem_cnt;
        if (consume) begin
            buf_cnt_next = rem_cnt + res_n;
            if (res_n == 2'd2) begin
                buf_data_next[0] = res0_data;
                buf_last_next[0] = res0_last;
                buf_data_next[1] = res1_data;
                buf_last_next[1] = res1_last;
            end
            else if (res_n == 2'd1) begin
                buf_data_next[rem_cnt[0]] = res0_data;
                buf_last_next[rem_cnt[0]] = res0_last;
            end
        end
    end

    assign in_valid_next = accept || (in_valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            first_hex_reg <= '0;
            buf_cnt_reg   <= 2'd0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            first_hex_reg <= first_hex_next;
            buf_cnt_reg   <= buf_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        buf_data_reg[0] <= buf_data_next[0];
        buf_data_reg[1] <= buf_data_next[1];
        buf_last_reg[0] <= buf_last_next[0];
        buf_last_reg[1] <= buf_last_next[1];
    end

    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= 2'd2)
        else $error("result buffer overfilled");

    a_pair_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && (res_n == 2'd2)) |-> (rem_cnt == 2'd0))
        else $error("two results taken without room");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> (phase_reg == PH_IDLE))
        else $error("escape left pending after end of string");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("unused escape phase reached");

endmodule
